/* rtl/crd_pkg.sv */
// Package: shared types, codes and sizes of the checked ring deque.
`default_nettype none
package crd_pkg;

	localparam int CAPACITY  = 64;
	localparam int WORD_W    = 32;
	localparam int GRP_SIZE  = 8;
	localparam int GRP_NUM   = (CAPACITY + GRP_SIZE - 1) / GRP_SIZE;

	typedef logic signed [WORD_W-1:0] word_t;

	typedef enum logic [1:0] {
		MODE_PUSH_FRONT = 2'd0,
		MODE_POP_FRONT  = 2'd1,
		MODE_PUSH_BACK  = 2'd2,
		MODE_POP_BACK   = 2'd3
	} mode_t;

	typedef enum logic [2:0] {
		CELL_HOLD,
		CELL_SHIFT_IN,
		CELL_SHIFT_OUT,
		CELL_FILL_BACK,
		CELL_DROP_BACK
	} cell_op_t;

	typedef struct packed {
		cell_op_t op;
		word_t    word;
	} cell_cmd_t;

	typedef enum logic [1:0] {
		ST_IDLE = 2'b01,
		ST_LOOK = 2'b10
	} state_t;

	localparam word_t NONE_WORD = '1;

endpackage
`default_nettype wire

/* rtl/crd_if.sv */
// Interfaces: input and result channels of the checked ring deque.
`default_nettype none
interface crd_in_if;
	import crd_pkg::*;
	logic  valid;
	logic  ready;
	logic  [1:0] mode;
	word_t data_value;
	modport source (output valid, output mode, output data_value, input ready);
	modport sink (input valid, input mode, input data_value, output ready);
endinterface

interface crd_out_if;
	import crd_pkg::*;
	logic  valid;
	logic  ready;
	word_t popped_value;
	logic  was_empty;
	logic  push_dropped;
	logic  all_matched;
	modport source (output valid, output popped_value, output was_empty,
		output push_dropped, output all_matched, input ready);
	modport sink (input valid, input popped_value, input was_empty,
		input push_dropped, input all_matched, output ready);
endinterface
`default_nettype wire

/* rtl/crd_cell.sv */
// One deque cell: holds a word and its occupied bit, shifts with its neighbors.
`default_nettype none
module crd_cell (
	input  wire                 clk,
	input  wire                 arst_n,
	input  crd_pkg::cell_cmd_t  cmd,
	input  crd_pkg::word_t      left_word,
	input  wire                 left_occ,
	input  crd_pkg::word_t      right_word,
	input  wire                 right_occ,
	output crd_pkg::word_t      word,
	output logic                occ,
	output logic                last
);
	import crd_pkg::*;

	word_t word_q;
	logic  occ_q;
	word_t word_d;
	logic  occ_d;

	always_comb begin
		word_d = word_q;
		occ_d  = occ_q;
		case (cmd.op)
			CELL_SHIFT_IN: begin
				word_d = left_word;
				occ_d  = left_occ;
			end
			CELL_SHIFT_OUT: begin
				word_d = right_word;
				occ_d  = right_occ;
			end
			CELL_FILL_BACK: begin
				if (!occ_q && left_occ) begin
					word_d = cmd.word;
					occ_d  = 1'b1;
				end
			end
			CELL_DROP_BACK: begin
				if (occ_q && !right_occ) begin
					occ_d = 1'b0;
				end
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk) begin
		word_q <= word_d;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			occ_q <= 1'b0;
		end else begin
			occ_q <= occ_d;
		end
	end

	assign word = word_q;
	assign occ  = occ_q;
	assign last = occ_q & ~right_occ;

endmodule
`default_nettype wire

/* rtl/crd_gather.sv */
// Back-word gather: registered two-level select of the last occupied cell.
`default_nettype none
module crd_gather (
	input  wire                    clk,
	input  crd_pkg::word_t         words [crd_pkg::CAPACITY],
	input  wire [crd_pkg::CAPACITY-1:0] lasts,
	output crd_pkg::word_t         back_word
);
	import crd_pkg::*;

	word_t grp_d  [GRP_NUM];
	word_t grp_s1 [GRP_NUM];

	always_comb begin
		for (int g = 0; g < GRP_NUM; g++) begin
			grp_d[g] = '0;
			for (int k = 0; k < GRP_SIZE; k++) begin
				if (g * GRP_SIZE + k < CAPACITY) begin
					if (lasts[g * GRP_SIZE + k]) begin
						grp_d[g] = grp_d[g] | words[g * GRP_SIZE + k];
					end
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		grp_s1 <= grp_d;
	end

	always_comb begin
		back_word = '0;
		for (int g = 0; g < GRP_NUM; g++) begin
			back_word = back_word | grp_s1[g];
		end
	end

endmodule
`default_nettype wire

/* rtl/checked_ring_deque.sv */
// Top level: checked deque built as a row of shifting cells.
// Flow: an accepted item is registered; in LOOK its result beat is registered
// once the output register is free or taken. No new item is taken until then;
// LOOK lets the registered back-word select settle before the cells update.
// Reset: arst_n clears all cells to empty, sets the match flag, idles the
// control and empties the result register; cell words stay unreset.
`default_nettype none
module checked_ring_deque (
	input  wire        clk,
	input  wire        arst_n,
	crd_in_if.sink     in_ch,
	crd_out_if.source  out_ch
);
	import crd_pkg::*;

	state_t    state_q;
	logic [1:0] mode_q;
	word_t     data_q;
	logic      match_q;
	logic      out_valid_q;
	word_t     popped_q;
	logic      empty_q;
	logic      dropped_q;

	word_t     cell_word [CAPACITY];
	logic [CAPACITY-1:0] cell_occ;
	logic [CAPACITY-1:0] cell_last;
	word_t     back_word;
	cell_cmd_t cmd;

	logic      in_beat;
	logic      go;
	logic      is_push;
	logic      is_front;
	logic      dq_empty;
	logic      dq_full;
	word_t     pop_word;
	word_t     popped_d;
	logic      empty_d;
	logic      dropped_d;
	logic      match_d;

	assign in_ch.ready = (state_q == ST_IDLE);
	assign in_beat     = in_ch.valid && in_ch.ready;
	assign go          = (state_q == ST_LOOK) && (!out_valid_q || out_ch.ready);

	assign is_push  = (mode_q == MODE_PUSH_FRONT) || (mode_q == MODE_PUSH_BACK);
	assign is_front = (mode_q == MODE_PUSH_FRONT) || (mode_q == MODE_POP_FRONT);
	assign dq_empty = ~cell_occ[0];
	assign dq_full  = cell_occ[CAPACITY-1];
	assign pop_word = is_front ? cell_word[0] : back_word;

	always_comb begin
		cmd.op    = CELL_HOLD;
		cmd.word  = data_q;
		popped_d  = NONE_WORD;
		empty_d   = 1'b0;
		dropped_d = 1'b0;
		match_d   = match_q;
		if (is_push) begin
			if (dq_full) begin
				dropped_d = 1'b1;
			end else begin
				cmd.op = is_front ? CELL_SHIFT_IN : CELL_FILL_BACK;
			end
		end else if (dq_empty) begin
			empty_d = 1'b1;
			if (data_q != NONE_WORD) begin
				match_d = 1'b0;
			end
		end else begin
			popped_d = pop_word;
			cmd.op   = is_front ? CELL_SHIFT_OUT : CELL_DROP_BACK;
			if (pop_word != data_q) begin
				match_d = 1'b0;
			end
		end
		if (!go) begin
			cmd.op = CELL_HOLD;
		end
	end

	for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
		word_t lw;
		logic  lo;
		word_t rw;
		logic  ro;
		if (i == 0) begin : g_head
			assign lw = data_q;
			assign lo = 1'b1;
		end else begin : g_body
			assign lw = cell_word[i-1];
			assign lo = cell_occ[i-1];
		end
		if (i == CAPACITY - 1) begin : g_tail
			assign rw = '0;
			assign ro = 1'b0;
		end else begin : g_inner
			assign rw = cell_word[i+1];
			assign ro = cell_occ[i+1];
		end
		crd_cell u_cell (
			.clk        (clk),
			.arst_n     (arst_n),
			.cmd        (cmd),
			.left_word  (lw),
			.left_occ   (lo),
			.right_word (rw),
			.right_occ  (ro),
			.word       (cell_word[i]),
			.occ        (cell_occ[i]),
			.last       (cell_last[i])
		);
	end

	crd_gather u_gather (
		.clk       (clk),
		.words     (cell_word),
		.lasts     (cell_last),
		.back_word (back_word)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			match_q     <= 1'b1;
			out_valid_q <= 1'b0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (in_beat) begin
						state_q <= ST_LOOK;
					end
				end
				ST_LOOK: begin
					if (go) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
			if (go) begin
				match_q     <= match_d;
				out_valid_q <= 1'b1;
			end else if (out_ch.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_beat) begin
			mode_q <= in_ch.mode;
			data_q <= in_ch.data_value;
		end
		if (go) begin
			popped_q  <= popped_d;
			empty_q   <= empty_d;
			dropped_q <= dropped_d;
		end
	end

	assign out_ch.valid        = out_valid_q;
	assign out_ch.popped_value = popped_q;
	assign out_ch.was_empty    = empty_q;
	assign out_ch.push_dropped = dropped_q;
	assign out_ch.all_matched  = match_q;

`ifndef ASSERT_OFF
	a_occ_prefix: assert property (@(posedge clk) disable iff (!arst_n)
		(cell_occ[CAPACITY-1:1] & ~cell_occ[CAPACITY-2:0]) == '0)
		else $error("occupied cells not contiguous from the front");

	a_one_back: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0(cell_last))
		else $error("more than one back cell");

	a_match_sticky: assert property (@(posedge clk) disable iff (!arst_n)
		!$rose(match_q))
		else $error("match flag set again after a mismatch");

	a_busy_after_beat: assert property (@(posedge clk) disable iff (!arst_n)
		in_beat |=> !in_ch.ready)
		else $error("new beat taken while an item is in flight");
`endif

endmodule
`default_nettype wire
